@@ design/cbmm_pkg.sv @@
// Shared types and constants for the console bus memory mapper.
package cbmm_pkg;

  localparam int unsigned ROM_BYTES  = 524288;
  localparam int unsigned BIOS_BYTES = 4096;
  localparam int unsigned RAM_BYTES  = 1024;

  localparam int unsigned RAM_AW  = $clog2(RAM_BYTES);
  localparam int unsigned BIOS_AW = $clog2(BIOS_BYTES);
  localparam int unsigned EXT_W   = 19;
  // bank number (8 bits) above a 14-bit bank offset
  localparam int unsigned CART_W  = 22;
  localparam logic [CART_W-1:0] ROM_MASK = CART_W'(ROM_BYTES - 1);

  // protection bit sequence, indexed by the decremented count
  localparam logic [15:0] PROT_PATTERN = 16'h0047;

  typedef enum logic [2:0] {
    TGT_RAM    = 3'd0,
    TGT_FIXED  = 3'd1,
    TGT_BUTTON = 3'd2,
    TGT_LCD    = 3'd3,
    TGT_AUDIO  = 3'd4,
    TGT_CART   = 3'd5,
    TGT_BIOS   = 3'd6
  } target_t;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // where the read byte of a stored result comes from
  typedef enum logic [1:0] {
    SRC_REG  = 2'd0,
    SRC_RAM  = 2'd1,
    SRC_BIOS = 2'd2
  } src_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  buttons;
  } in_beat_t;

  typedef struct packed {
    target_t          target;
    logic [7:0]       read_data;
    logic             data_valid;
    logic [EXT_W-1:0] ext_address;
    logic             ext_write;
    logic [7:0]       ext_write_data;
  } out_beat_t;

endpackage

@@ design/console_bus_memory_mapper.sv @@
// Console bus memory mapper: address decode, work RAM, BIOS store, banking.
//
// One bus access (beat) in, one result beat out. Each accepted beat is decoded
// in a single pass: the work RAM or BIOS store is read or written at the edge
// that accepts the beat, and the decoded result lands in the result register
// at that same edge, so a new beat can enter every cycle while in_stall is
// low. A skid register behind the result register lets the block take one
// more beat while the output is stalled; in_stall is driven from that skid
// register only. Writes to 0x8000 and 0xC000 set the low and high cartridge
// banks. A read of the low bank while the protection count is nonzero
// decrements the count and answers one bit of the protection pattern in bit 1.
// cfg_we with cfg_wdata loads the protection count; write it only while the
// block is idle. RAM and BIOS contents are undefined until written. No
// clearing pass runs after reset.
module console_bus_memory_mapper (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  cbmm_pkg::in_beat_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cbmm_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata
);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic [7:0] ram [cbmm_pkg::RAM_BYTES];
  logic [7:0] bios [cbmm_pkg::BIOS_BYTES];
  logic [7:0] ram_q;
  logic [7:0] bios_q;

  logic [7:0] low_bank;
  logic [7:0] high_bank;
  logic [3:0] prot_count;
  logic [3:0] prot_count_next;

  // result register (stage) and skid register
  logic                r_valid;
  logic                r_valid_next;
  cbmm_pkg::out_beat_t r_beat;
  cbmm_pkg::src_t      r_src;
  logic                s_valid;
  logic                s_valid_next;
  cbmm_pkg::out_beat_t s_beat;

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic accept;
  logic out_fire;
  logic park;              // move the stalled result into the skid register
  cbmm_pkg::out_beat_t r_resolved;

  assign in_stall  = s_valid;
  assign accept    = in_valid && !s_valid;
  assign out_valid = s_valid || r_valid;
  assign out_fire  = out_valid && !out_stall;
  assign park      = !s_valid && r_valid && out_stall && accept;

  // memory read data is muxed in after the result register
  always_comb begin
    r_resolved = r_beat;
    case (r_src)
      cbmm_pkg::SRC_RAM:  r_resolved.read_data = ram_q;
      cbmm_pkg::SRC_BIOS: r_resolved.read_data = bios_q;
      default:            r_resolved.read_data = r_beat.read_data;
    endcase
  end

  assign out_data = s_valid ? s_beat : r_resolved;

  always_comb begin
    if (accept) begin
      r_valid_next = 1'b1;
    end else if (!s_valid && out_fire) begin
      r_valid_next = 1'b0;
    end else begin
      r_valid_next = r_valid;
    end
    if (s_valid) begin
      s_valid_next = !out_fire;
    end else begin
      s_valid_next = park;
    end
  end

  // ---------------------------------------------------------------------------
  // Decode
  // ---------------------------------------------------------------------------
  logic [15:0] a;
  logic        wr;

  logic [cbmm_pkg::RAM_AW-1:0]  ram_idx;
  logic [cbmm_pkg::BIOS_AW-1:0] bios_idx;
  logic                          ram_we;
  logic                          bios_we;
  logic                          ram_sel;
  logic                          bios_sel;
  logic [13:0]                   cart_off;
  logic [7:0]                    cart_bank;
  logic [cbmm_pkg::CART_W-1:0]   cart_full;
  logic [3:0]                    prot_dec;
  cbmm_pkg::out_beat_t           dec_beat;
  cbmm_pkg::src_t                dec_src;

  assign a        = in_data.address;
  assign wr       = (in_data.op == cbmm_pkg::OP_WRITE);
  assign ram_idx  = a[cbmm_pkg::RAM_AW-1:0];
  assign bios_idx = a[cbmm_pkg::BIOS_AW-1:0];
  assign ram_sel  = (a <= 16'h1FFF);
  assign bios_sel = (a >= 16'hE000);
  assign ram_we   = accept && ram_sel && wr;
  assign bios_we  = accept && bios_sel && wr;
  assign prot_dec = prot_count - 4'd1;

  // bank offset; both windows start 0x2000 into a 16 KiB frame
  assign cart_off  = (a <= 16'h9FFF) ? 14'(a - 16'h6000) : 14'(a - 16'hA000);
  assign cart_bank = (a <= 16'h9FFF) ? low_bank : high_bank;
  assign cart_full = {cart_bank, cart_off} & cbmm_pkg::ROM_MASK;

  always_comb begin
    dec_beat        = '0;
    dec_src         = cbmm_pkg::SRC_REG;
    prot_count_next = prot_count;
    if (ram_sel) begin
      dec_beat.target = cbmm_pkg::TGT_RAM;
      if (!wr) begin
        dec_beat.data_valid = 1'b1;
        dec_src             = cbmm_pkg::SRC_RAM;
      end
    end else if (a <= 16'h3FFF) begin
      dec_beat.target     = cbmm_pkg::TGT_FIXED;
      dec_beat.read_data  = wr ? 8'h00 : 8'hFF;
      dec_beat.data_valid = !wr;
    end else if (a <= 16'h43FF) begin
      dec_beat.target      = cbmm_pkg::TGT_AUDIO;
      dec_beat.ext_address = cbmm_pkg::EXT_W'(a[3:0]);
      if (wr) begin
        dec_beat.ext_write      = 1'b1;
        dec_beat.ext_write_data = in_data.write_data;
      end else begin
        dec_beat.read_data  = 8'hFF;
        dec_beat.data_valid = 1'b1;
      end
    end else if (a <= 16'h47FF) begin
      dec_beat.target     = cbmm_pkg::TGT_BUTTON;
      dec_beat.read_data  = wr ? 8'h00 : in_data.buttons;
      dec_beat.data_valid = !wr;
    end else if (a <= 16'h4BFF) begin
      dec_beat.target     = cbmm_pkg::TGT_FIXED;
      dec_beat.data_valid = !wr;
    end else if (a <= 16'h4FFF) begin
      dec_beat.target     = cbmm_pkg::TGT_FIXED;
      dec_beat.read_data  = wr ? 8'h00 : 8'hFF;
      dec_beat.data_valid = !wr;
    end else if (a <= 16'h53FF) begin
      dec_beat.target      = cbmm_pkg::TGT_LCD;
      dec_beat.ext_address = cbmm_pkg::EXT_W'(a[9:0]);
      if (wr) begin
        dec_beat.ext_write      = 1'b1;
        dec_beat.ext_write_data = in_data.write_data;
      end
    end else if (a <= 16'h59FF) begin
      dec_beat.target     = cbmm_pkg::TGT_FIXED;
      dec_beat.read_data  = wr ? 8'h00 : 8'hFF;
      dec_beat.data_valid = !wr;
    end else if (a <= 16'h5FFF) begin
      dec_beat.target     = cbmm_pkg::TGT_FIXED;
      dec_beat.read_data  = wr ? 8'h00 : 8'h5B;
      dec_beat.data_valid = !wr;
    end else if (!bios_sel) begin
      dec_beat.target = cbmm_pkg::TGT_CART;
      if (!wr) begin
        if (a <= 16'h9FFF && prot_count != 4'd0) begin
          // protection read: answer one pattern bit in bit 1
          prot_count_next     = prot_dec;
          dec_beat.read_data  = {6'd0, cbmm_pkg::PROT_PATTERN[prot_dec], 1'b0};
          dec_beat.data_valid = 1'b1;
        end else begin
          dec_beat.ext_address = cart_full[cbmm_pkg::EXT_W-1:0];
        end
      end
    end else begin
      dec_beat.target = cbmm_pkg::TGT_BIOS;
      if (!wr) begin
        dec_beat.data_valid = 1'b1;
        dec_src             = cbmm_pkg::SRC_BIOS;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Memories: written and read at the accepting edge
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (ram_we) begin
      ram[ram_idx] <= in_data.write_data;
    end
    if (accept) begin
      ram_q <= ram[ram_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (bios_we) begin
      bios[bios_idx] <= in_data.write_data;
    end
    if (accept) begin
      bios_q <= bios[bios_idx];
    end
  end

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid    <= 1'b0;
      s_valid    <= 1'b0;
      low_bank   <= 8'd0;
      high_bank  <= 8'd0;
      prot_count <= 4'd0;
    end else begin
      r_valid <= r_valid_next;
      s_valid <= s_valid_next;
      if (cfg_we) begin
        prot_count <= cfg_wdata;
      end else if (accept) begin
        prot_count <= prot_count_next;
      end
      if (accept && wr && a == 16'h8000) begin
        low_bank <= in_data.write_data;
      end
      if (accept && wr && a == 16'hC000) begin
        high_bank <= in_data.write_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      r_beat <= dec_beat;
      r_src  <= dec_src;
    end
    if (park) begin
      s_beat <= r_resolved;
    end
  end

endmodule

@@ design/cbmm_checker.sv @@
// Port-level checker for the console bus memory mapper, with its bind.
module cbmm_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input cbmm_pkg::out_beat_t out_data
);

  // nothing pending right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("result or stall present after reset");

  // forwarded writes only go to lcd or audio
  a_ext_write_target: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.ext_write |->
      (out_data.target == cbmm_pkg::TGT_LCD || out_data.target == cbmm_pkg::TGT_AUDIO))
    else $error("forwarded write to wrong target");

  // internally served regions never carry an external address
  a_no_ext_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.target == cbmm_pkg::TGT_RAM ||
                  out_data.target == cbmm_pkg::TGT_BIOS ||
                  out_data.target == cbmm_pkg::TGT_BUTTON ||
                  out_data.target == cbmm_pkg::TGT_FIXED) |->
      out_data.ext_address == '0 && !out_data.ext_write)
    else $error("external address on internal target");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

endmodule

bind console_bus_memory_mapper cbmm_checker u_cbmm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
